### hw/rtl/dkfp_pkg.sv
// Shared types, status codes and helpers for the distinct key frequency profiler.
package dkfp_pkg;

	// Width of the slot field carried between the tables and the top level
	localparam int SLOT_W = 8;

	// Width of all event counters
	localparam int CNT_W = 32;

	// Lookup outcome codes, as shown on the status outputs
	typedef enum logic [1:0] {
		ST_HIT  = 2'd0,
		ST_NEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	// Outcome of one table lookup, with the counts after the update
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [CNT_W-1:0]    cnt;
		logic [CNT_W-1:0]    aux_cnt;
	} lookup_t;

	// Saturating increment of a counter
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

### hw/rtl/dkfp_tally_table.sv
// Fill-ordered table of distinct keys with saturating hit counters.
module dkfp_tally_table #(
	parameter int ENTRIES = 8,
	parameter bit AUX     = 1'b0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [31:0]                   key,
	input  logic                          upd,
	input  logic                          aux_inc,
	output dkfp_pkg::lookup_t             res,
	output logic [$clog2(ENTRIES+1)-1:0]  fill_nxt
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W = $clog2(ENTRIES + 1);

	logic [31:0]                 keys_q [ENTRIES];
	logic [dkfp_pkg::CNT_W-1:0]  cnt_q  [ENTRIES];
	logic [FILL_W-1:0]           fill_q;

	logic [ENTRIES-1:0]          hit_vec;
	logic                        hit;
	logic                        full;
	logic                        add;
	logic [IDX_W-1:0]            hit_idx;
	logic [dkfp_pkg::CNT_W-1:0]  cnt_sel;
	logic [dkfp_pkg::CNT_W-1:0]  aux_sel;
	logic [dkfp_pkg::CNT_W-1:0]  cnt_new;
	logic [dkfp_pkg::CNT_W-1:0]  aux_new;

	// Compare the key against every filled entry and pick the one that hits
	always_comb begin
		hit_idx = '0;
		cnt_sel = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = (FILL_W'(i) < fill_q) && (keys_q[i] == key);
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			cnt_sel = cnt_sel | (cnt_q[i] & {dkfp_pkg::CNT_W{hit_vec[i]}});
		end
		hit  = |hit_vec;
		full = (fill_q == FILL_W'(ENTRIES));
		add  = !hit && !full;
	end

	// Form the lookup result and the counts to store
	always_comb begin
		res = '0;
		cnt_new = dkfp_pkg::CNT_W'(1);
		aux_new = aux_inc ? dkfp_pkg::CNT_W'(1) : '0;
		if (hit) begin
			cnt_new = dkfp_pkg::sat_inc(cnt_sel);
			aux_new = aux_inc ? dkfp_pkg::sat_inc(aux_sel) : aux_sel;
			res.status = dkfp_pkg::ST_HIT;
			res.slot   = dkfp_pkg::SLOT_W'(hit_idx);
		end else if (!full) begin
			res.status = dkfp_pkg::ST_NEW;
			res.slot   = dkfp_pkg::SLOT_W'(fill_q);
		end else begin
			res.status = dkfp_pkg::ST_FULL;
		end
		if (!full || hit) begin
			res.cnt     = cnt_new;
			res.aux_cnt = aux_new;
		end
		fill_nxt = (upd && add) ? fill_q + FILL_W'(1) : fill_q;
	end

	// Advance the fill count on an append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_nxt;
		end
	end

	// Write the hit entry or the newly appended entry
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (upd && (hit_vec[i] || (add && fill_q == FILL_W'(i)))) begin
				cnt_q[i] <= cnt_new;
				if (!hit) begin
					keys_q[i] <= key;
				end
			end
		end
	end

	// Second counter per entry, present only where asked for
	if (AUX) begin : g_aux
		logic [dkfp_pkg::CNT_W-1:0] aux_q [ENTRIES];

		always_comb begin
			aux_sel = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				aux_sel = aux_sel | (aux_q[i] & {dkfp_pkg::CNT_W{hit_vec[i]}});
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (upd && (hit_vec[i] || (add && fill_q == FILL_W'(i)))) begin
					aux_q[i] <= aux_new;
				end
			end
		end
	end else begin : g_no_aux
		assign aux_sel = '0;
	end

endmodule

### hw/rtl/distinct_key_frequency_profiler.sv
// Top level of the distinct key frequency profiler.
//
// Input channel (in_valid / in_stall) carries one event: token_id,
// return_address and label_matched. Output channel (out_valid / out_stall)
// carries one result per event: token and site lookup outcomes with the
// updated entry counts, the running totals and the number of distinct tokens.
// A transfer happens at a clock edge with valid high and stall low.
//
// Each event is captured in an input register, looked up against both tables
// by one pass of parallel key compares, and its result lands in the output
// register while the tables and counters update at the same edge. The event
// passes the input register and then the result register; throughput is one
// event per cycle while the receiver does not stall.
//
// Reset clears the fill counts, the totals and both valid flags; table
// contents are not cleared. When the receiver stalls, the result holds and the
// event in the input register waits; in_stall rises only while both are full.
module distinct_key_frequency_profiler #(
	parameter int TOKEN_ENTRIES = 24,
	parameter int SITE_ENTRIES  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] token_id,
	input  logic [31:0] return_address,
	input  logic        label_matched,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  token_status,
	output logic [4:0]  token_slot,
	output logic [31:0] token_calls,
	output logic [31:0] token_matches,
	output logic [1:0]  site_status,
	output logic [2:0]  site_slot,
	output logic [31:0] site_count,
	output logic [31:0] total_events,
	output logic [31:0] total_matched,
	output logic [31:0] token_overflows,
	output logic [31:0] site_overflows,
	output logic [4:0]  distinct_tokens
);

	localparam int TOK_FILL_W  = $clog2(TOKEN_ENTRIES + 1);
	localparam int SITE_FILL_W = $clog2(SITE_ENTRIES + 1);

	// Input stage
	logic        valid_s1;
	logic [31:0] token_s1;
	logic [31:0] ra_s1;
	logic        matched_s1;

	// Control
	logic out_ready;
	logic fire;

	// Table results
	dkfp_pkg::lookup_t        tok_res;
	dkfp_pkg::lookup_t        site_res;
	logic [TOK_FILL_W-1:0]    tok_fill_nxt;
	logic [SITE_FILL_W-1:0]   site_fill_nxt;
	logic [31:0]              tok_fill_ext;

	// Running counters
	logic [31:0] event_total_q;
	logic [31:0] matched_total_q;
	logic [31:0] tok_ovf_q;
	logic [31:0] site_ovf_q;
	logic [31:0] event_total_nxt;
	logic [31:0] matched_total_nxt;
	logic [31:0] tok_ovf_nxt;
	logic [31:0] site_ovf_nxt;

	// Result register
	logic        out_valid_q;
	logic [1:0]  token_status_q;
	logic [4:0]  token_slot_q;
	logic [31:0] token_calls_q;
	logic [31:0] token_matches_q;
	logic [1:0]  site_status_q;
	logic [2:0]  site_slot_q;
	logic [31:0] site_count_q;
	logic [4:0]  distinct_tokens_q;

	// Handshake: work the held event when the result register can take it
	assign out_ready = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	// Capture the incoming event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			token_s1   <= token_id;
			ra_s1      <= return_address;
			matched_s1 <= label_matched;
		end
	end

	// Token table: call count plus matched count
	dkfp_tally_table #(
		.ENTRIES (TOKEN_ENTRIES),
		.AUX     (1'b1)
	) u_token_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (token_s1),
		.upd      (fire),
		.aux_inc  (matched_s1),
		.res      (tok_res),
		.fill_nxt (tok_fill_nxt)
	);

	// Site table: touched by matched events only
	dkfp_tally_table #(
		.ENTRIES (SITE_ENTRIES),
		.AUX     (1'b0)
	) u_site_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (ra_s1),
		.upd      (fire && matched_s1),
		.aux_inc  (1'b0),
		.res      (site_res),
		.fill_nxt (site_fill_nxt)
	);

	// Next values of the running counters
	always_comb begin
		event_total_nxt   = dkfp_pkg::sat_inc(event_total_q);
		matched_total_nxt = matched_s1 ? dkfp_pkg::sat_inc(matched_total_q)
		                               : matched_total_q;
		tok_ovf_nxt = (tok_res.status == dkfp_pkg::ST_FULL) ?
		              dkfp_pkg::sat_inc(tok_ovf_q) : tok_ovf_q;
		site_ovf_nxt = (matched_s1 && site_res.status == dkfp_pkg::ST_FULL) ?
		               dkfp_pkg::sat_inc(site_ovf_q) : site_ovf_q;
		tok_fill_ext = 32'(tok_fill_nxt);
	end

	// Update counters and the valid flag of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_total_q   <= '0;
			matched_total_q <= '0;
			tok_ovf_q       <= '0;
			site_ovf_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (fire) begin
				event_total_q   <= event_total_nxt;
				matched_total_q <= matched_total_nxt;
				tok_ovf_q       <= tok_ovf_nxt;
				site_ovf_q      <= site_ovf_nxt;
				out_valid_q     <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			token_status_q    <= tok_res.status;
			token_slot_q      <= tok_res.slot[4:0];
			token_calls_q     <= tok_res.cnt;
			token_matches_q   <= tok_res.aux_cnt;
			distinct_tokens_q <= tok_fill_ext[4:0];
			if (matched_s1) begin
				site_status_q <= site_res.status;
				site_slot_q   <= site_res.slot[2:0];
				site_count_q  <= site_res.cnt;
			end else begin
				site_status_q <= dkfp_pkg::ST_NONE;
				site_slot_q   <= '0;
				site_count_q  <= '0;
			end
		end
	end

	// Drive the output ports
	assign out_valid       = out_valid_q;
	assign token_status    = token_status_q;
	assign token_slot      = token_slot_q;
	assign token_calls     = token_calls_q;
	assign token_matches   = token_matches_q;
	assign site_status     = site_status_q;
	assign site_slot       = site_slot_q;
	assign site_count      = site_count_q;
	assign total_events    = event_total_q;
	assign total_matched   = matched_total_q;
	assign token_overflows = tok_ovf_q;
	assign site_overflows  = site_ovf_q;
	assign distinct_tokens = distinct_tokens_q;

endmodule

### hw/rtl/dkfp_checker.sv
// Port-level checks for the distinct key frequency profiler, bound to the top level.
module dkfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  token_status,
	input logic [4:0]  token_slot,
	input logic [31:0] token_calls,
	input logic [31:0] token_matches,
	input logic [1:0]  site_status,
	input logic [2:0]  site_slot,
	input logic [31:0] site_count
);

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A new token entry starts with one call
	a_new_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_status == dkfp_pkg::ST_NEW |-> token_calls == 32'd1)
		else $error("new token entry does not start at one call");

	// A full token table reports no slot and no counts
	a_full_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_status == dkfp_pkg::ST_FULL |->
		token_slot == 5'd0 && token_calls == 32'd0 && token_matches == 32'd0)
		else $error("full token table reports nonzero fields");

	// Unrecorded or full site reports no slot and no count
	a_no_site: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (site_status == dkfp_pkg::ST_NONE ||
		site_status == dkfp_pkg::ST_FULL) |-> site_slot == 3'd0 && site_count == 32'd0)
		else $error("unrecorded site reports nonzero fields");

	// Matched count never passes the call count
	a_match_le_calls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_matches <= token_calls)
		else $error("token matched count exceeds call count");

endmodule

bind distinct_key_frequency_profiler dkfp_checker u_dkfp_checker (.*);
